>>> design/ocsd_pkg.sv
// shared widths, codes and types for the over-current sigma threshold detector
`timescale 1ns / 1ps

package ocsd_pkg;

   // field widths
   localparam int KIND_W      = 3;
   localparam int ADC_W       = 10;
   localparam int STORED_W    = 16;
   localparam int THR_W       = 16;
   localparam int STATUS_W    = 3;
   localparam int NOMINAL_W   = 10;
   localparam int SIGMA_W     = 9;
   localparam int K_W         = 4;
   localparam int MIN_THR_W   = 10;

   // configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIGMA_MULT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_THRESH = 1'd1;

   // register reset values
   localparam logic [K_W-1:0]       K_RESET       = 4'd3;
   localparam logic [MIN_THR_W-1:0] MIN_THR_RESET = 10'd20;

   // arithmetic units
   localparam int MUL_W     = 10;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int MSQ_W     = 2 * ADC_W;
   localparam int ROOT_IN_W = 16;

   // value limits
   localparam int ADC_MAX = 1023;
   localparam logic [NOMINAL_W-1:0] MEAN_BAD     = 10'd1023;
   localparam logic [STORED_W-1:0]  NOMINAL_LIM  = 16'd1023;
   localparam logic [STORED_W-1:0]  SIGMA_LIM    = 16'd500;
   localparam logic [SIGMA_W-1:0]   SIGMA_SUBST  = 9'd4;
   localparam logic [THR_W-1:0]     THR_SAT      = 16'hFFFF;

   // default length of a calibration run
   localparam int CAL_SAMPLES_DEFAULT = 256;

   typedef enum logic [KIND_W-1:0] {
      KIND_CHECK      = 3'd0,
      KIND_CAL_SAMPLE = 3'd1,
      KIND_START      = 3'd2,
      KIND_RECAL      = 3'd3,
      KIND_LOAD       = 3'd4
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_NONE     = 3'd0,
      STAT_STARTED  = 3'd1,
      STAT_REFUSED  = 3'd2,
      STAT_DONE     = 3'd3,
      STAT_INVALID  = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_CHECK_MUL,
      ST_ACC_MUL,
      ST_DIVIDE,
      ST_MEAN_MUL,
      ST_ROOT,
      ST_WRITE
   } state_type;

   // strobes from the sequencer to the datapath and units
   typedef struct packed {
      logic req_ready;
      logic mul_start;
      logic div_start;
      logic root_start;
      logic rsp_load;
   } seq_ctl_type;

endpackage

>>> design/ocsd_channels.sv
// valid/ready channel interfaces for request, response and register writes
`timescale 1ns / 1ps

interface ocsd_req_if;
   import ocsd_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [KIND_W-1:0]     kind;
   logic [ADC_W-1:0]      sample;
   logic                  motor_stopped;
   logic [STORED_W-1:0]   stored_nominal;
   logic [STORED_W-1:0]   stored_sigma;

   modport source (output valid, kind, sample, motor_stopped, stored_nominal, stored_sigma,
                   input ready);
   modport sink   (input valid, kind, sample, motor_stopped, stored_nominal, stored_sigma,
                   output ready);
endinterface

interface ocsd_rsp_if;
   import ocsd_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  over_current;
   logic [THR_W-1:0]      trip_threshold;
   logic [STATUS_W-1:0]   status;
   logic                  calibrated;
   logic [NOMINAL_W-1:0]  nominal_level;
   logic [SIGMA_W-1:0]    sigma_level;
   logic                  save_request;

   modport source (output valid, over_current, trip_threshold, status, calibrated,
                   nominal_level, sigma_level, save_request,
                   input ready);
   modport sink   (input valid, over_current, trip_threshold, status, calibrated,
                   nominal_level, sigma_level, save_request,
                   output ready);
endinterface

interface ocsd_csr_if;
   import ocsd_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CSR_INDEX_W-1:0]  index;
   logic [CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> design/ocsd_mul.sv
// shift-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps

module ocsd_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ocsd_pkg::MUL_W-1:0]   op_a,
   input  logic [ocsd_pkg::MUL_W-1:0]   op_b,
   output logic                         done,
   output logic [ocsd_pkg::PROD_W-1:0]  product
);
   import ocsd_pkg::*;

   localparam int CNT_W = $clog2(MUL_W + 1);

   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [PROD_W-1:0] mcand_ff, mcand_in;
   logic [MUL_W-1:0]  mplier_ff, mplier_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   // one partial product added per cycle
   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         acc_in    = '0;
         mcand_in  = PROD_W'(op_a);
         mplier_in = op_b;
         cnt_in    = CNT_W'(MUL_W);
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // operands and accumulator
   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      cnt_ff    <= cnt_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

>>> design/ocsd_cdiv.sv
// two-lane restoring divider by a fixed divisor, one quotient bit per cycle
`timescale 1ns / 1ps

module ocsd_cdiv #(
   parameter int DIVIDEND_W = 32,
   parameter int DIVISOR    = ocsd_pkg::CAL_SAMPLES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [1:0][DIVIDEND_W-1:0]     dividend,
   output logic                           done,
   output logic [1:0][DIVIDEND_W-1:0]     quotient
);
   localparam int REM_W = $clog2(DIVISOR) + 1;
   localparam int CNT_W = $clog2(DIVIDEND_W + 1);
   localparam logic [REM_W:0] DIVISOR_K = DIVISOR[REM_W:0];

   logic [1:0][DIVIDEND_W-1:0] dq_ff, dq_in;
   logic [1:0][REM_W-1:0]      rem_ff, rem_in;
   logic [1:0][REM_W:0]        shifted;
   logic [1:0][REM_W:0]        diff;
   logic [1:0]                 fits;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;

   // trial subtraction per lane
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         shifted[i] = {rem_ff[i], dq_ff[i][DIVIDEND_W-1]};
         fits[i]    = shifted[i] >= DIVISOR_K;
         diff[i]    = shifted[i] - DIVISOR_K;
      end
   end

   // next state: dividend shifts out on top, quotient bits enter below
   always_comb begin
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dq_in   = dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int i = 0; i < 2; i++) begin
            dq_in[i]  = {dq_ff[i][DIVIDEND_W-2:0], fits[i]};
            rem_in[i] = fits[i] ? diff[i][REM_W-1:0] : shifted[i][REM_W-1:0];
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // lanes
   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = dq_ff;

endmodule

>>> design/ocsd_sqrt.sv
// bit-pair square root with round to nearest, one root bit per cycle
`timescale 1ns / 1ps

module ocsd_sqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [ocsd_pkg::ROOT_IN_W-1:0]  radicand,
   output logic                            done,
   output logic [ocsd_pkg::SIGMA_W-1:0]    root
);
   import ocsd_pkg::*;

   localparam logic [ROOT_IN_W-1:0] TOP_BIT = ROOT_IN_W'(1) << (ROOT_IN_W - 2);

   logic [ROOT_IN_W-1:0] rem_ff, rem_in;
   logic [ROOT_IN_W-1:0] root_ff, root_in;
   logic [ROOT_IN_W-1:0] bit_ff, bit_in;
   logic [ROOT_IN_W:0]   trial;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   assign trial = {1'b0, root_ff} + {1'b0, bit_ff};

   // one trial subtraction per cycle, bit moves down two places
   always_comb begin
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = radicand;
         root_in = '0;
         bit_in  = TOP_BIT;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_in  = rem_ff - trial[ROOT_IN_W-1:0];
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
   end

   // round up when the remainder exceeds the root
   assign done = done_ff;
   assign root = root_ff[SIGMA_W-1:0] + SIGMA_W'(rem_ff > root_ff);

endmodule

>>> design/overcurrent_sigma_threshold_detector_unit.sv
// top level: sequencer, calibration state and threshold check
//
//  channel | dir | beat contents
//  --------+-----+-----------------------------------------------------------
//  req_bus | in  | kind, sample, motor_stopped, stored_nominal, stored_sigma
//  rsp_bus | out | over_current, trip_threshold, status, calibrated,
//          |     | nominal_level, sigma_level, save_request
//  csr_bus | in  | index, data (always ready)
//
// one beat is worked at a time; checks and calibration samples within a run wait
// for the shift-add multiplier; other kinds go straight to the result write.
// the sample that ends a run adds the serial divider (one bit per cycle of the
// square sum), a mean square and an 8-step root.
// reset is synchronous and restores registers and calibration state at once.
// a result waits in the output register; the next beat is taken meanwhile.
`timescale 1ns / 1ps

module overcurrent_sigma_threshold_detector_unit #(
   parameter int CALIBRATION_SAMPLES = ocsd_pkg::CAL_SAMPLES_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   ocsd_req_if.sink      req_bus,
   ocsd_rsp_if.source    rsp_bus,
   ocsd_csr_if.sink      csr_bus
);
   import ocsd_pkg::*;

   localparam int SUM_W = $clog2(CALIBRATION_SAMPLES * ADC_MAX + 1);
   localparam int SQ_W  = $clog2(longint'(CALIBRATION_SAMPLES) * ADC_MAX * ADC_MAX + 1);
   localparam int CNT_W = $clog2(CALIBRATION_SAMPLES + 1);
   localparam logic [CNT_W-1:0] RUN_LEN = CNT_W'(CALIBRATION_SAMPLES);
   localparam int TSUM_W = PROD_W + 1;

   state_type   state_ff, state_in;
   seq_ctl_type ctl;

   // latched beat
   kind_type              kind_ff;
   logic [ADC_W-1:0]      sample_ff;
   logic                  stopped_ff;
   logic [STORED_W-1:0]   snom_ff;
   logic [STORED_W-1:0]   ssig_ff;

   // registers
   logic [K_W-1:0]        k_ff;
   logic [MIN_THR_W-1:0]  min_ff;

   // calibration state
   logic                  sampling_ff, sampling_in;
   logic [CNT_W-1:0]      taken_ff, taken_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [SQ_W-1:0]       sq_ff, sq_in;
   logic [NOMINAL_W-1:0]  nominal_ff, nominal_in;
   logic [SIGMA_W-1:0]    sigma_ff, sigma_in;
   logic [NOMINAL_W-1:0]  mean_ff, mean_in;
   logic [MSQ_W-1:0]      msq_ff, msq_in;

   // pending result
   logic                  res_over_ff, res_over_in;
   logic [THR_W-1:0]      res_thr_ff, res_thr_in;
   status_type            res_status_ff, res_status_in;
   logic                  res_save_ff, res_save_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_over_ff;
   logic [THR_W-1:0]      rsp_thr_ff;
   status_type            rsp_status_ff;
   logic                  rsp_cal_ff;
   logic [NOMINAL_W-1:0]  rsp_nom_ff;
   logic [SIGMA_W-1:0]    rsp_sig_ff;
   logic                  rsp_save_ff;

   // unit hookup
   logic [MUL_W-1:0]          mul_a, mul_b;
   logic                      mul_done;
   logic [PROD_W-1:0]         prod;
   logic                      div_done;
   logic [1:0][SQ_W-1:0]      quot;
   logic                      root_done;
   logic [SIGMA_W-1:0]        root;
   logic [ROOT_IN_W-1:0]      radicand;

   // helpers
   logic [CNT_W-1:0]   taken_next;
   logic               run_last;
   logic               rsp_free;
   logic               req_take;
   logic [TSUM_W-1:0]  thr_sum;
   logic [THR_W-1:0]   thr_sat;
   logic [THR_W-1:0]   thr_final;
   logic [MSQ_W-1:0]   mean_sq;
   logic [MSQ_W-1:0]   variance;

   assign taken_next = taken_ff + CNT_W'(1);
   assign run_last   = taken_next >= RUN_LEN;
   assign rsp_free   = !rsp_valid_ff || rsp_bus.ready;
   assign req_take   = req_bus.valid && ctl.req_ready;

   // threshold: nominal plus k sigma, saturated, floored at the minimum
   assign thr_sum   = TSUM_W'(nominal_ff) + TSUM_W'(prod);
   assign thr_sat   = (thr_sum > TSUM_W'(THR_SAT)) ? THR_SAT : thr_sum[THR_W-1:0];
   assign thr_final = (thr_sat < THR_W'(min_ff)) ? THR_W'(min_ff) : thr_sat;

   // variance clamped to the root input range
   assign mean_sq  = prod;
   assign variance = (msq_ff > mean_sq) ? (msq_ff - mean_sq) : '0;
   assign radicand = (variance > MSQ_W'(THR_SAT)) ? THR_SAT : variance[ROOT_IN_W-1:0];

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (kind_ff == KIND_CHECK) begin
               state_in = ST_CHECK_MUL;
            end else if (kind_ff == KIND_CAL_SAMPLE && sampling_ff) begin
               state_in = ST_ACC_MUL;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_CHECK_MUL: begin
            if (mul_done) state_in = ST_WRITE;
         end
         ST_ACC_MUL: begin
            if (mul_done) state_in = run_last ? ST_DIVIDE : ST_WRITE;
         end
         ST_DIVIDE: begin
            if (div_done) state_in = ST_MEAN_MUL;
         end
         ST_MEAN_MUL: begin
            if (mul_done) state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (root_done) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      ctl = '0;
      unique case (state_ff)
         ST_IDLE:     ctl.req_ready = 1'b1;
         ST_DISPATCH: ctl.mul_start = (kind_ff == KIND_CHECK) ||
                                      (kind_ff == KIND_CAL_SAMPLE && sampling_ff);
         ST_ACC_MUL:  ctl.div_start = mul_done && run_last;
         ST_DIVIDE:   ctl.mul_start = div_done;
         ST_MEAN_MUL: ctl.root_start = mul_done;
         ST_WRITE:    ctl.rsp_load = rsp_free;
         default:     ctl = '0;
      endcase
   end

   // multiplier operand select
   always_comb begin
      mul_a = MUL_W'(sample_ff);
      mul_b = MUL_W'(sample_ff);
      unique case (state_ff)
         ST_DISPATCH: begin
            if (kind_ff == KIND_CHECK) begin
               mul_a = MUL_W'(k_ff);
               mul_b = MUL_W'(sigma_ff);
            end
         end
         ST_DIVIDE: begin
            mul_a = quot[1][MUL_W-1:0];
            mul_b = quot[1][MUL_W-1:0];
         end
         default: ;
      endcase
   end

   // calibration state and pending result
   always_comb begin
      sampling_in   = sampling_ff;
      taken_in      = taken_ff;
      sum_in        = sum_ff;
      sq_in         = sq_ff;
      nominal_in    = nominal_ff;
      sigma_in      = sigma_ff;
      mean_in       = mean_ff;
      msq_in        = msq_ff;
      res_over_in   = res_over_ff;
      res_thr_in    = res_thr_ff;
      res_status_in = res_status_ff;
      res_save_in   = res_save_ff;
      unique case (state_ff)
         ST_DISPATCH: begin
            res_over_in   = 1'b0;
            res_thr_in    = '0;
            res_status_in = STAT_NONE;
            res_save_in   = 1'b0;
            unique case (kind_ff)
               KIND_START: begin
                  if (!stopped_ff) begin
                     res_status_in = STAT_REFUSED;
                  end else if (!sampling_ff) begin
                     sampling_in   = 1'b1;
                     taken_in      = '0;
                     sum_in        = '0;
                     sq_in         = '0;
                     res_status_in = STAT_STARTED;
                  end
               end
               KIND_RECAL: begin
                  nominal_in = '0;
                  sigma_in   = '0;
                  if (stopped_ff) begin
                     sampling_in   = 1'b1;
                     taken_in      = '0;
                     sum_in        = '0;
                     sq_in         = '0;
                     res_status_in = STAT_STARTED;
                  end else begin
                     sampling_in   = 1'b0;
                     res_status_in = STAT_REFUSED;
                  end
               end
               KIND_LOAD: begin
                  nominal_in = (snom_ff > NOMINAL_LIM) ? '0 : snom_ff[NOMINAL_W-1:0];
                  sigma_in   = (ssig_ff > SIGMA_LIM) ? SIGMA_SUBST : ssig_ff[SIGMA_W-1:0];
               end
               default: ;
            endcase
         end
         ST_CHECK_MUL: begin
            if (mul_done) begin
               res_thr_in  = thr_final;
               res_over_in = THR_W'(sample_ff) > thr_final;
            end
         end
         ST_ACC_MUL: begin
            if (mul_done) begin
               sum_in   = sum_ff + SUM_W'(sample_ff);
               sq_in    = sq_ff + SQ_W'(prod);
               taken_in = taken_next;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               mean_in = quot[1][NOMINAL_W-1:0];
               msq_in  = quot[0][MSQ_W-1:0];
            end
         end
         ST_ROOT: begin
            if (root_done) begin
               sampling_in = 1'b0;
               if (mean_ff == '0 || mean_ff >= MEAN_BAD) begin
                  nominal_in    = '0;
                  sigma_in      = '0;
                  res_status_in = STAT_INVALID;
               end else begin
                  nominal_in    = mean_ff;
                  sigma_in      = root;
                  res_status_in = STAT_DONE;
                  res_save_in   = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   // output register handoff
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         k_ff         <= K_RESET;
         min_ff       <= MIN_THR_RESET;
         sampling_ff  <= 1'b0;
         taken_ff     <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         nominal_ff   <= '0;
         sigma_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sampling_ff  <= sampling_in;
         taken_ff     <= taken_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         nominal_ff   <= nominal_in;
         sigma_ff     <= sigma_in;
         if (csr_bus.valid) begin
            unique case (csr_bus.index)
               CSR_SIGMA_MULT: k_ff   <= csr_bus.data[K_W-1:0];
               CSR_MIN_THRESH: min_ff <= csr_bus.data[MIN_THR_W-1:0];
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff    <= kind_type'(req_bus.kind);
         sample_ff  <= req_bus.sample;
         stopped_ff <= req_bus.motor_stopped;
         snom_ff    <= req_bus.stored_nominal;
         ssig_ff    <= req_bus.stored_sigma;
      end
      mean_ff       <= mean_in;
      msq_ff        <= msq_in;
      res_over_ff   <= res_over_in;
      res_thr_ff    <= res_thr_in;
      res_status_ff <= res_status_in;
      res_save_ff   <= res_save_in;
      if (ctl.rsp_load) begin
         rsp_over_ff   <= res_over_ff;
         rsp_thr_ff    <= res_thr_ff;
         rsp_status_ff <= res_status_ff;
         rsp_cal_ff    <= !sampling_ff && (nominal_ff != '0);
         rsp_nom_ff    <= nominal_ff;
         rsp_sig_ff    <= sigma_ff;
         rsp_save_ff   <= res_save_ff;
      end
   end

   // arithmetic units
   ocsd_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (ctl.mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (prod)
   );

   // sums including the sample that ends the run
   ocsd_cdiv #(
      .DIVIDEND_W (SQ_W),
      .DIVISOR    (CALIBRATION_SAMPLES)
   ) u_cdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (ctl.div_start),
      .dividend ({SQ_W'(sum_in), sq_in}),
      .done     (div_done),
      .quotient (quot)
   );

   ocsd_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (ctl.root_start),
      .radicand (radicand),
      .done     (root_done),
      .root     (root)
   );

   // ports
   assign req_bus.ready          = ctl.req_ready;
   assign csr_bus.ready          = 1'b1;
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.over_current   = rsp_over_ff;
   assign rsp_bus.trip_threshold = rsp_thr_ff;
   assign rsp_bus.status         = rsp_status_ff;
   assign rsp_bus.calibrated     = rsp_cal_ff;
   assign rsp_bus.nominal_level  = rsp_nom_ff;
   assign rsp_bus.sigma_level    = rsp_sig_ff;
   assign rsp_bus.save_request   = rsp_save_ff;

endmodule

>>> sim/testbench.sv
// self-checking testbench for the over-current sigma threshold detector
`timescale 1ns / 1ps

module testbench;
   import ocsd_pkg::*;

   localparam int CLOCK_PERIOD = 8;
   localparam int RESET_CYCLES = 10;
   localparam int CAL_RUN      = CAL_SAMPLES_DEFAULT;
   localparam int PHASE_BEATS  = 150;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES  = 100;
   localparam int CYCLE_LIMIT  = 1000000;

   // kinds outside the defined set, ignored by the block
   localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
   localparam logic [KIND_W-1:0] KIND_UNUSED_LAST  = 3'd7;

   typedef enum {PROF_NOISY, PROF_SPREAD, PROF_ZERO, PROF_ONE, PROF_TOP} sample_profile_type;

   typedef struct packed {
      logic                 over_current;
      logic [THR_W-1:0]     trip_threshold;
      logic [STATUS_W-1:0]  status;
      logic                 calibrated;
      logic [NOMINAL_W-1:0] nominal_level;
      logic [SIGMA_W-1:0]   sigma_level;
      logic                 save_request;
   } sense_result_type;

   logic clock = 1'b0;
   logic reset;

   ocsd_req_if req_bus ();
   ocsd_rsp_if rsp_bus ();
   ocsd_csr_if csr_bus ();

   overcurrent_sigma_threshold_detector_unit #(
      .CALIBRATION_SAMPLES(CAL_RUN)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // mirrored detector state and registers
   logic                 cal_running;
   logic [12:0]          cal_count;
   logic [31:0]          cal_sum;
   logic [31:0]          cal_square_sum;
   logic [NOMINAL_W-1:0] nominal_now;
   logic [SIGMA_W-1:0]   sigma_now;
   logic [K_W-1:0]       k_now;
   logic [MIN_THR_W-1:0] min_thr_now;

   sense_result_type expected_readings[$];

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int error_count        = 0;
   int beats_sent         = 0;
   int useful_beats       = 0;
   int results_checked    = 0;
   int runs_done          = 0;
   int runs_rejected      = 0;
   int cycle_count        = 0;

   // clock
   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // floor(sqrt(v) + 0.5), v is at most 65535 here
   function automatic logic [31:0] rounded_root(input logic [31:0] value);
      logic [31:0] root;
      root = 0;
      while ((root + 1) * (root + 1) <= value) root++;
      if (value - root * root > root) root++;
      return root;
   endfunction

   // opens a calibration run if the motor is at rest and none is going
   function automatic logic [STATUS_W-1:0] open_run(input logic stopped);
      if (!stopped) return STAT_REFUSED;
      if (cal_running) return STAT_NONE;
      cal_running    = 1'b1;
      cal_count      = '0;
      cal_sum        = '0;
      cal_square_sum = '0;
      return STAT_STARTED;
   endfunction

   // advances the mirrored state by one beat and gives the expected result
   function automatic sense_result_type predict_sense(input logic [KIND_W-1:0] kind,
                                                      input logic [ADC_W-1:0] sample,
                                                      input logic stopped,
                                                      input logic [STORED_W-1:0] stored_nom,
                                                      input logic [STORED_W-1:0] stored_sig);
      sense_result_type r;
      logic [31:0] thr;
      logic [31:0] mean;
      logic [31:0] mean_sq;
      logic [31:0] square_mean;
      logic [31:0] variance;
      r = '0;
      case (kind)
         KIND_CHECK: begin
            thr = 32'(nominal_now) + 32'(k_now) * 32'(sigma_now);
            if (thr > 32'hFFFF) thr = 32'hFFFF;
            if (thr < 32'(min_thr_now)) thr = 32'(min_thr_now);
            r.trip_threshold = thr[THR_W-1:0];
            r.over_current   = (32'(sample) > thr);
         end
         KIND_CAL_SAMPLE: begin
            if (cal_running) begin
               cal_sum        += 32'(sample);
               cal_square_sum += 32'(sample) * 32'(sample);
               cal_count      += 13'd1;
               if (cal_count >= CAL_RUN) begin
                  mean        = cal_sum / 32'(CAL_RUN);
                  square_mean = cal_square_sum / 32'(CAL_RUN);
                  mean_sq     = mean * mean;
                  variance    = (square_mean > mean_sq) ? square_mean - mean_sq : 32'd0;
                  if (variance > 32'd65535) variance = 32'd65535;
                  cal_running = 1'b0;
                  if (mean == 0 || mean >= 32'(MEAN_BAD)) begin
                     nominal_now = '0;
                     sigma_now   = '0;
                     r.status    = STAT_INVALID;
                  end else begin
                     nominal_now    = mean[NOMINAL_W-1:0];
                     sigma_now      = SIGMA_W'(rounded_root(variance));
                     r.status       = STAT_DONE;
                     r.save_request = 1'b1;
                  end
               end
            end
         end
         KIND_START: r.status = open_run(stopped);
         KIND_RECAL: begin
            cal_running = 1'b0;
            nominal_now = '0;
            sigma_now   = '0;
            r.status    = open_run(stopped);
         end
         KIND_LOAD: begin
            nominal_now = (stored_nom > NOMINAL_LIM) ? '0 : stored_nom[NOMINAL_W-1:0];
            sigma_now   = (stored_sig > SIGMA_LIM) ? SIGMA_SUBST : stored_sig[SIGMA_W-1:0];
         end
         default: ;
      endcase
      r.calibrated    = !cal_running && nominal_now != 0;
      r.nominal_level = nominal_now;
      r.sigma_level   = sigma_now;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // compare each result beat with the oldest expectation
   always @(posedge clock) begin : result_check
      sense_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_readings.size() == 0) begin
            $error("result beat with no expectation waiting");
            error_count++;
         end else begin
            want = expected_readings.pop_front();
            check_field("over_current", 16'(want.over_current), 16'(rsp_bus.over_current));
            check_field("trip_threshold", want.trip_threshold, rsp_bus.trip_threshold);
            check_field("status", 16'(want.status), 16'(rsp_bus.status));
            check_field("calibrated", 16'(want.calibrated), 16'(rsp_bus.calibrated));
            check_field("nominal_level", 16'(want.nominal_level),
                        16'(rsp_bus.nominal_level));
            check_field("sigma_level", 16'(want.sigma_level), 16'(rsp_bus.sigma_level));
            check_field("save_request", 16'(want.save_request), 16'(rsp_bus.save_request));
            results_checked++;
            if (want.status == STAT_DONE) runs_done++;
            if (want.status == STAT_INVALID) runs_rejected++;
         end
      end
   end

   // send one request beat, with a random gap in front of it
   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [ADC_W-1:0] sample,
                            input logic stopped, input logic [STORED_W-1:0] stored_nom,
                            input logic [STORED_W-1:0] stored_sig);
      logic ignored;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.kind           <= kind;
      req_bus.sample         <= sample;
      req_bus.motor_stopped  <= stopped;
      req_bus.stored_nominal <= stored_nom;
      req_bus.stored_sigma   <= stored_sig;
      do @(posedge clock); while (!req_bus.ready);
      ignored = (kind == KIND_CAL_SAMPLE && !cal_running) || kind > KIND_LOAD
                || (kind == KIND_START && stopped && cal_running);
      expected_readings.push_back(predict_sense(kind, sample, stopped, stored_nom, stored_sig));
      beats_sent++;
      if (!ignored) useful_beats++;
   endtask

   // stop sending and let every outstanding result come back
   task automatic wait_until_drained();
      req_bus.valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write both registers; upper data bits are junk the block must drop
   task automatic set_config(input logic [K_W-1:0] k, input logic [MIN_THR_W-1:0] min_thr);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= CSR_SIGMA_MULT;
      csr_bus.data  <= {12'($urandom), k};
      do @(posedge clock); while (!csr_bus.ready);
      k_now = k;
      csr_bus.index <= CSR_MIN_THRESH;
      csr_bus.data  <= {6'($urandom), min_thr};
      do @(posedge clock); while (!csr_bus.ready);
      min_thr_now = min_thr;
      csr_bus.valid <= 1'b0;
   endtask

   // any kind, stored words half in range and half raw
   task automatic send_random_item();
      int pick;
      logic [KIND_W-1:0] kind;
      pick = $urandom_range(99);
      if (pick < 40) kind = KIND_CHECK;
      else if (pick < 55) kind = KIND_CAL_SAMPLE;
      else if (pick < 65) kind = KIND_START;
      else if (pick < 72) kind = KIND_RECAL;
      else if (pick < 90) kind = KIND_LOAD;
      else kind = 3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
      send_item(kind, 10'($urandom), 1'($urandom),
                $urandom_range(1) ? 16'($urandom_range(0, NOMINAL_LIM)) : 16'($urandom),
                $urandom_range(1) ? 16'($urandom_range(0, SIGMA_LIM)) : 16'($urandom));
   endtask

   // start a run and feed it a full set of samples of the given shape
   task automatic run_calibration(input sample_profile_type profile, input int check_pct,
                                  input int noise_pct);
      int center;
      int spread;
      int value;
      center = $urandom_range(1, ADC_MAX - 1);
      spread = ($urandom_range(4) == 0) ? 0 :
               $urandom_range(1, ($urandom_range(3) == 0) ? 400 : 30);
      if (cal_running || $urandom_range(1) == 0)
         send_item(KIND_RECAL, 10'($urandom), 1'b1, 16'($urandom), 16'($urandom));
      else
         send_item(KIND_START, 10'($urandom), 1'b1, 16'($urandom), 16'($urandom));
      for (int n = 0; n < CAL_RUN; n++) begin
         if ($urandom_range(99) < check_pct)
            send_item(KIND_CHECK, 10'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
         else if ($urandom_range(99) < noise_pct)
            send_random_item();
         case (profile)
            PROF_NOISY:  value = center + int'($urandom_range(0, 2 * spread)) - spread;
            PROF_SPREAD: value = $urandom_range(0, ADC_MAX);
            PROF_ZERO:   value = ($urandom_range(9) == 0) ? 1 : 0;
            PROF_ONE:    value = 1;
            default:     value = ADC_MAX;
         endcase
         if (value < 0) value = 0;
         if (value > ADC_MAX) value = ADC_MAX;
         send_item(KIND_CAL_SAMPLE, 10'(value), 1'($urandom), 16'($urandom), 16'($urandom));
      end
   endtask

   // mostly calibration runs with random content, the rest random beats
   task automatic run_traffic_phase(input int sender_pct, input int receiver_pct,
                                    input logic [K_W-1:0] k,
                                    input logic [MIN_THR_W-1:0] min_thr);
      int first;
      int pick;
      sample_profile_type profile;
      wait_until_drained();
      set_config(k, min_thr);
      sender_idle_pct    = sender_pct;
      receiver_stall_pct = receiver_pct;
      first = useful_beats;
      while (useful_beats - first < PHASE_BEATS) begin
         if ($urandom_range(99) < 5) begin
            pick = $urandom_range(99);
            if (pick < 70) profile = PROF_NOISY;
            else if (pick < 82) profile = PROF_SPREAD;
            else if (pick < 88) profile = PROF_ZERO;
            else if (pick < 94) profile = PROF_ONE;
            else profile = PROF_TOP;
            run_calibration(profile, 8, 1);
         end else begin
            send_random_item();
         end
      end
   endtask

   // checks against an uncalibrated block: minimum threshold rules
   task automatic test_uncalibrated_checks();
      send_item(KIND_CHECK, 10'd0, 1'b0, 16'($urandom), 16'($urandom));
      send_item(KIND_CHECK, 10'(ADC_MAX), 1'b1, 16'($urandom), 16'($urandom));
      send_item(KIND_CHECK, 10'(MIN_THR_RESET), 1'b0, 16'($urandom), 16'($urandom));
      send_item(KIND_CHECK, 10'(MIN_THR_RESET + 1), 1'b1, 16'($urandom), 16'($urandom));
   endtask

   // calibration sample while idle and the undefined kinds
   task automatic test_ignored_kinds();
      send_item(KIND_CAL_SAMPLE, 10'(ADC_MAX), 1'b1, 16'($urandom), 16'($urandom));
      for (int k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST; k++)
         send_item(3'(k), 10'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
   endtask

   // stored values at and beyond their limits, then a check around the threshold
   task automatic test_stored_values();
      send_item(KIND_LOAD, 10'($urandom), 1'b1, NOMINAL_LIM, SIGMA_LIM);
      send_item(KIND_LOAD, 10'($urandom), 1'b0, NOMINAL_LIM + 16'd1, SIGMA_LIM + 16'd1);
      send_item(KIND_LOAD, 10'($urandom), 1'b1, 16'hFFFF, 16'hFFFF);
      send_item(KIND_LOAD, 10'($urandom), 1'b0, 16'd0, 16'd0);
      send_item(KIND_LOAD, 10'($urandom), 1'b1, 16'd100, 16'd10);
      // reset k of 3 gives 100 + 30
      send_item(KIND_CHECK, 10'd130, 1'b1, 16'($urandom), 16'($urandom));
      send_item(KIND_CHECK, 10'd131, 1'b0, 16'($urandom), 16'($urandom));
   endtask

   // start refusals, start during a run, checks and loads mid-run, recalibration
   task automatic test_start_and_recal();
      send_item(KIND_START, 10'($urandom), 1'b0, 16'($urandom), 16'($urandom));
      send_item(KIND_START, 10'($urandom), 1'b1, 16'($urandom), 16'($urandom));
      send_item(KIND_START, 10'($urandom), 1'b1, 16'($urandom), 16'($urandom));
      send_item(KIND_START, 10'($urandom), 1'b0, 16'($urandom), 16'($urandom));
      send_item(KIND_CHECK, 10'(ADC_MAX), 1'b1, 16'($urandom), 16'($urandom));
      send_item(KIND_LOAD, 10'($urandom), 1'b1, 16'd200, 16'd20);
      send_item(KIND_RECAL, 10'($urandom), 1'b0, 16'($urandom), 16'($urandom));
      send_item(KIND_RECAL, 10'($urandom), 1'b1, 16'($urandom), 16'($urandom));
      send_item(KIND_RECAL, 10'($urandom), 1'b1, 16'($urandom), 16'($urandom));
   endtask

   // runs that end with a mean of 0, a mean of 1, a saturated mean and a clamped variance
   task automatic test_calibration_edges();
      wait_until_drained();
      set_config(4'd15, 10'd0);
      run_calibration(PROF_ZERO, 5, 0);
      run_calibration(PROF_ONE, 5, 0);
      run_calibration(PROF_TOP, 5, 0);
      run_calibration(PROF_SPREAD, 5, 0);
   endtask

   // random traffic under each idling mix and several register settings
   task automatic test_random_traffic();
      run_traffic_phase(0, 0, 4'd0, 10'd1023);
      run_traffic_phase(87, 0, 4'($urandom), 10'($urandom));
      run_traffic_phase(0, 87, 4'($urandom), 10'($urandom));
      run_traffic_phase(25, 25, 4'($urandom_range(1, 14)), 10'($urandom_range(1, 100)));
   endtask

   initial begin
      reset                  <= 1'b1;
      req_bus.valid          <= 1'b0;
      req_bus.kind           <= KIND_CHECK;
      req_bus.sample         <= '0;
      req_bus.motor_stopped  <= 1'b0;
      req_bus.stored_nominal <= '0;
      req_bus.stored_sigma   <= '0;
      csr_bus.valid          <= 1'b0;
      csr_bus.index          <= CSR_SIGMA_MULT;
      csr_bus.data           <= '0;

      cal_running    = 1'b0;
      cal_count      = '0;
      cal_sum        = '0;
      cal_square_sum = '0;
      nominal_now    = '0;
      sigma_now      = '0;
      k_now          = K_RESET;
      min_thr_now    = MIN_THR_RESET;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_uncalibrated_checks();
      test_ignored_kinds();
      test_stored_values();
      test_start_and_recal();
      test_calibration_edges();
      test_random_traffic();

      wait_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run covered %0d request beats (%0d acted on) and %0d checked results",
               beats_sent, useful_beats, results_checked);
      $display("%0d calibration runs completed, %0d rejected for a bad mean",
               runs_done + runs_rejected, runs_rejected);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
